/* rtl/mnlm_pkg.sv */
// ----------------------------------------------------------------------------
// mnlm_pkg
// Shared constants and types of the multi-needle line matcher.
// ----------------------------------------------------------------------------
package mnlm_pkg;

    localparam int PATTERN_SLOTS     = 16;
    localparam int MAX_PATTERN_BYTES = 32;

    localparam int SLOT_W = 4;
    localparam int OFF_W  = 5;
    localparam int BYTE_W = 8;
    localparam int ACT_W  = 5;
    localparam int LEN_W  = $clog2(MAX_PATTERN_BYTES + 1);
    localparam int IDX_W  = $clog2(MAX_PATTERN_BYTES);

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SCAN = 1'b1;

    typedef enum logic
    {
        ST_RUN,
        ST_REPLAY
    } mode_t;

    // Shared data broadcast to every slot
    typedef struct packed
    {
        logic [BYTE_W-1:0] data;
        logic [OFF_W-1:0]  off;
        logic              last;
    } cell_bus_t;

    // Per-slot strobes
    typedef struct packed
    {
        logic load;
        logic step;
        logic clear;
    } slot_ctrl_t;

endpackage

/* rtl/mnlm_cell.sv */
// ----------------------------------------------------------------------------
// mnlm_cell
// One pattern byte and its prefix-match bit; on every step the match bit
// takes its left neighbor's match bit ANDed with the compare of its byte.
// ----------------------------------------------------------------------------
module mnlm_cell
    import mnlm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [BYTE_W-1:0] data,
    input  logic              we,
    input  logic              step,
    input  logic              clear,
    input  logic              prev_match,
    output logic              match,
    output logic              cmp_match
);

    logic [BYTE_W-1:0] pat_reg;
    logic [BYTE_W-1:0] pat_next;
    logic              match_reg;
    logic              match_next;

    assign cmp_match = prev_match && (pat_reg == data);
    assign match     = match_reg;

    always_comb
    begin
        pat_next = we ? data : pat_reg;
    end

    always_comb
    begin
        match_next = match_reg;
        if (clear)
        begin
            match_next = 1'b0;
        end
        else if (step)
        begin
            match_next = cmp_match;
        end
    end

    always_ff @(posedge clk)
    begin
        pat_reg <= pat_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

endmodule

/* rtl/mnlm_slot.sv */
// ----------------------------------------------------------------------------
// mnlm_slot
// Chain of pattern cells for one slot, with the pattern length and the
// match tap at the pattern's last byte.
// ----------------------------------------------------------------------------
module mnlm_slot
    import mnlm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_bus_t  bus,
    input  slot_ctrl_t ctrl,
    output logic       tap_hit
);

    logic [MAX_PATTERN_BYTES-1:0] match_vec;
    logic [MAX_PATTERN_BYTES-1:0] cmp_vec;
    logic [MAX_PATTERN_BYTES-1:0] we_vec;
    logic [LEN_W-1:0]             len_reg;
    logic [LEN_W-1:0]             len_next;
    logic [IDX_W-1:0]             tap_idx;

    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN_BYTES; j++)
        begin : g_cell
            logic prev;
            if (j == 0)
            begin : g_head
                assign prev = 1'b1;
            end
            else
            begin : g_body
                assign prev = match_vec[j-1];
            end

            assign we_vec[j] = ctrl.load && (int'(bus.off) == j);

            mnlm_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .data       (bus.data),
                .we         (we_vec[j]),
                .step       (ctrl.step),
                .clear      (ctrl.clear),
                .prev_match (prev),
                .match      (match_vec[j]),
                .cmp_match  (cmp_vec[j])
            );
        end
    endgenerate

    always_comb
    begin
        len_next = len_reg;
        if (ctrl.load && bus.last)
        begin
            len_next = LEN_W'(bus.off) + LEN_W'(1);
        end
    end

    assign tap_idx = IDX_W'(len_reg - LEN_W'(1));
    assign tap_hit = (len_reg != '0) && cmp_vec[tap_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
        end
        else
        begin
            len_reg <= len_next;
        end
    end

endmodule

/* rtl/multi_needle_line_matcher.sv */
// ----------------------------------------------------------------------------
// multi_needle_line_matcher
// Flags each text line that contains any of the stored byte patterns.
//
// s_* takes words: tuser[0] = 1 scans one line byte (tuser[1] set when a
// byte is present, tlast ends the line), tuser[0] = 0 loads a pattern byte.
// Each slot is a chain of cells that runs a shift-and prefix match, one
// line byte per cycle while s_tready is high. A line-final word's hit flag
// is registered into the output buffer for m_*; a two-word output buffer
// keeps s_tready high while one result waits. cfg_* writes the active
// pattern count at any cycle. A load word does not itself hold s_tready
// low. After loads in the middle of a line, the next scan word carrying a
// byte waits while the window is replayed through the reloaded slots;
// otherwise throughput is one word per cycle. Reset clears the line state,
// lengths and count; pattern bytes hold garbage until loaded. With two
// results unread, s_tready drops until m_tready takes one.
// ----------------------------------------------------------------------------
module multi_needle_line_matcher
    import mnlm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] pattern_slot, [8:4] byte_offset, [16:9] byte_value,
    // [17] pattern_final, [23:18] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    input  logic                   s_tlast,
    // [0] operation, [1] carries_byte
    input  logic [IN_TUSER_W-1:0]  s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] line_hit, [7:1] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [ACT_W-1:0]       cfg_data
);

    logic [SLOT_W-1:0] f_slot;
    logic [OFF_W-1:0]  f_off;
    logic [BYTE_W-1:0] f_byte;
    logic              f_pfinal;
    logic              f_op;
    logic              f_carries;

    logic in_fire;
    logic load_ok;
    logic scan_byte;
    logic line_end;
    logic need_replay;
    logic replay_step;
    logic scan_hit;
    logic push_hit;
    logic pop;

    mode_t mode_reg;
    mode_t mode_next;
    logic [IDX_W-1:0]         cnt_reg;
    logic [IDX_W-1:0]         cnt_next;
    logic [PATTERN_SLOTS-1:0] dirty_reg;
    logic [PATTERN_SLOTS-1:0] dirty_next;
    logic [LEN_W-1:0]         seen_reg;
    logic [LEN_W-1:0]         seen_next;
    logic                     hit_reg;
    logic                     hit_next;
    logic [ACT_W-1:0]         active_reg;
    logic [ACT_W-1:0]         active_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic                     out_hit_reg;
    logic                     out_hit_next;
    logic                     skid_valid_reg;
    logic                     skid_valid_next;
    logic                     skid_hit_reg;
    logic                     skid_hit_next;

    logic [BYTE_W-1:0] recent_reg  [MAX_PATTERN_BYTES];
    logic [BYTE_W-1:0] recent_next [MAX_PATTERN_BYTES];

    cell_bus_t                bus;
    slot_ctrl_t               ctrl [PATTERN_SLOTS];
    logic [PATTERN_SLOTS-1:0] load_sel;
    logic [PATTERN_SLOTS-1:0] tap_vec;
    logic [PATTERN_SLOTS-1:0] active_vec;

    assign f_slot    = s_tdata[3:0];
    assign f_off     = s_tdata[8:4];
    assign f_byte    = s_tdata[16:9];
    assign f_pfinal  = s_tdata[17];
    assign f_op      = s_tuser[0];
    assign f_carries = s_tuser[1];

    assign need_replay = (mode_reg == ST_RUN) && s_tvalid && (f_op == OP_SCAN)
                         && f_carries && (dirty_reg != '0);
    assign s_tready    = (mode_reg == ST_RUN) && !need_replay && !skid_valid_reg;
    assign in_fire     = s_tvalid && s_tready;
    assign replay_step = (mode_reg == ST_REPLAY);

    assign load_ok   = in_fire && (f_op == OP_LOAD)
                       && (int'(f_off) < MAX_PATTERN_BYTES)
                       && (int'(f_slot) < PATTERN_SLOTS);
    assign scan_byte = in_fire && (f_op == OP_SCAN) && f_carries;
    assign line_end  = in_fire && (f_op == OP_SCAN) && s_tlast;

    always_comb
    begin
        bus.data = replay_step ? recent_reg[cnt_reg] : f_byte;
        bus.off  = f_off;
        bus.last = f_pfinal;
    end

    genvar k;
    generate
        for (k = 0; k < PATTERN_SLOTS; k++)
        begin : g_slot
            assign load_sel[k]   = load_ok && (int'(f_slot) == k);
            assign active_vec[k] = int'(active_reg) > k;

            always_comb
            begin
                ctrl[k].load  = load_sel[k];
                ctrl[k].step  = scan_byte || (replay_step && dirty_reg[k]);
                ctrl[k].clear = line_end || (need_replay && dirty_reg[k]);
            end

            mnlm_slot u_slot
            (
                .clk     (clk),
                .rst_n   (rst_n),
                .bus     (bus),
                .ctrl    (ctrl[k]),
                .tap_hit (tap_vec[k])
            );
        end
    endgenerate

    assign scan_hit = scan_byte && ((tap_vec & active_vec) != '0);
    assign push_hit = hit_reg || scan_hit;
    assign pop      = out_valid_reg && m_tready;

    // Replay sequencer and dirty slots
    always_comb
    begin
        mode_next  = mode_reg;
        cnt_next   = cnt_reg;
        dirty_next = dirty_reg;
        if (seen_reg != '0)
        begin
            dirty_next = dirty_reg | load_sel;
        end
        case (mode_reg)
            ST_RUN:
            begin
                if (need_replay)
                begin
                    mode_next = ST_REPLAY;
                    cnt_next  = IDX_W'(seen_reg - LEN_W'(1));
                end
            end
            ST_REPLAY:
            begin
                cnt_next = cnt_reg - IDX_W'(1);
                if (cnt_reg == '0)
                begin
                    mode_next  = ST_RUN;
                    dirty_next = '0;
                end
            end
            default:
            begin
                mode_next = ST_RUN;
            end
        endcase
        if (line_end)
        begin
            dirty_next = '0;
        end
    end

    // Line state
    always_comb
    begin
        seen_next = seen_reg;
        hit_next  = hit_reg;
        for (int i = 0; i < MAX_PATTERN_BYTES; i++)
        begin
            recent_next[i] = recent_reg[i];
        end
        if (line_end)
        begin
            seen_next = '0;
            hit_next  = 1'b0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                recent_next[i] = '0;
            end
        end
        else if (scan_byte)
        begin
            if (int'(seen_reg) < MAX_PATTERN_BYTES)
            begin
                seen_next = seen_reg + LEN_W'(1);
            end
            hit_next       = push_hit;
            recent_next[0] = f_byte;
            for (int i = 1; i < MAX_PATTERN_BYTES; i++)
            begin
                recent_next[i] = recent_reg[i-1];
            end
        end
    end

    // Output buffer: main word plus skid word
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_hit_next    = out_hit_reg;
        skid_valid_next = skid_valid_reg;
        skid_hit_next   = skid_hit_reg;
        if (pop)
        begin
            out_valid_next  = skid_valid_reg;
            out_hit_next    = skid_hit_reg;
            skid_valid_next = 1'b0;
        end
        if (line_end)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_hit_next   = push_hit;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_hit_next   = push_hit;
            end
        end
    end

    always_comb
    begin
        active_next = cfg_valid ? cfg_data : active_reg;
    end

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = OUT_TDATA_W'(out_hit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= ST_RUN;
            cnt_reg        <= '0;
            dirty_reg      <= '0;
            seen_reg       <= '0;
            hit_reg        <= 1'b0;
            active_reg     <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                recent_reg[i] <= '0;
            end
        end
        else
        begin
            mode_reg       <= mode_next;
            cnt_reg        <= cnt_next;
            dirty_reg      <= dirty_next;
            seen_reg       <= seen_next;
            hit_reg        <= hit_next;
            active_reg     <= active_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
            for (int i = 0; i < MAX_PATTERN_BYTES; i++)
            begin
                recent_reg[i] <= recent_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_hit_reg  <= out_hit_next;
        skid_hit_reg <= skid_hit_next;
    end

    a_replay_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == ST_REPLAY) |-> !s_tready)
        else $error("input accepted during window replay");

    a_skid_behind_main : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held without main output word");

    a_dirty_needs_bytes : assert property (@(posedge clk) disable iff (!rst_n)
        (dirty_reg != '0) |-> (seen_reg != '0))
        else $error("dirty slot on an empty line");

    a_seen_counts : assert property (@(posedge clk) disable iff (!rst_n)
        (scan_byte && !s_tlast && (int'(seen_reg) < MAX_PATTERN_BYTES))
        |=> (seen_reg == LEN_W'($past(seen_reg) + LEN_W'(1))))
        else $error("byte count did not advance");

endmodule
